@@ hdl/qbv_pkg.sv @@
package qbv_pkg;

   // field and register widths
   localparam int WORD_W    = 32;
   localparam int LIMIT_W   = 11;
   localparam int QUADS_W   = 11;
   localparam int SLOT_O_W  = 5;
   localparam int BSLOTS_W  = 6;
   localparam int PADDR_W   = 3;

   // batch sizing
   localparam int MAX_QUADS         = 1024;
   localparam int NUM_SLOTS_DEFAULT = 32;

   // register reset values
   localparam logic [WORD_W-1:0]  WHITE_RESET = '0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

   // register indexes (taken from paddr bit 2)
   localparam logic REG_WHITE = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   // result kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   // opcodes
   localparam logic OP_DRAW  = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       emit_mark;
      logic       mark_last;
      logic       search;
      logic       emit_vtx;
      logic [1:0] corner;
   } qbv_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic flush_due;
      logic search_done;
   } qbv_sts_type;

endpackage

@@ hdl/qbv_csr.sv @@
module qbv_csr
   import qbv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [WORD_W-1:0]   pwdata,
   output logic [WORD_W-1:0]   prdata,
   output logic                pready,
   output logic [WORD_W-1:0]   white_id,
   output logic [LIMIT_W-1:0]  quad_limit
);

   logic [WORD_W-1:0]  white_ff, white_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               wr_en;
   logic               reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   // register write decode
   always_comb begin
      white_in = white_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_WHITE: white_in = pwdata;
            REG_LIMIT: limit_in = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= WHITE_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         white_ff <= white_in;
         limit_ff <= limit_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_WHITE: prdata = white_ff;
         REG_LIMIT: prdata = WORD_W'(limit_ff);
         default:   prdata = '0;
      endcase
   end

   assign white_id   = white_ff;
   assign quad_limit = limit_ff;

endmodule

@@ hdl/qbv_ctrl.sv @@
module qbv_ctrl
   import qbv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        opcode,
   output logic        busy,
   input  qbv_sts_type sts,
   output qbv_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MARK = 4'b0010,
      ST_SRCH = 4'b0100,
      ST_VTX  = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic       close_ff, close_in;
   logic [1:0] corner_ff, corner_in;

   assign busy = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      close_in   = close_ff;
      corner_in  = corner_ff;
      cmd        = '0;
      cmd.corner = corner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               close_in = (opcode == OP_CLOSE);
               if (opcode == OP_CLOSE || sts.flush_due) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_SRCH;
               end
            end
         end
         ST_MARK: begin
            cmd.emit_mark = 1'b1;
            cmd.mark_last = close_ff;
            state_in      = close_ff ? ST_IDLE : ST_SRCH;
         end
         ST_SRCH: begin
            cmd.search = 1'b1;
            if (sts.search_done) begin
               corner_in = 2'd0;
               state_in  = ST_VTX;
            end
         end
         ST_VTX: begin
            cmd.emit_vtx = 1'b1;
            corner_in    = corner_ff + 2'd1;
            if (corner_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         close_ff  <= 1'b0;
         corner_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         close_ff  <= close_in;
         corner_ff <= corner_in;
      end
   end

endmodule

@@ hdl/qbv_datapath.sv @@
module qbv_datapath
   import qbv_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  qbv_cmd_type                cmd,
   output qbv_sts_type                sts,
   input  logic [WORD_W-1:0]          white_id,
   input  logic [LIMIT_W-1:0]         quad_limit,
   input  logic [WORD_W-1:0]          req_texture_id,
   input  logic signed [WORD_W-1:0]   req_axis0_x,
   input  logic signed [WORD_W-1:0]   req_axis0_y,
   input  logic signed [WORD_W-1:0]   req_axis1_x,
   input  logic signed [WORD_W-1:0]   req_axis1_y,
   input  logic signed [WORD_W-1:0]   req_trans_x,
   input  logic signed [WORD_W-1:0]   req_trans_y,
   input  logic [WORD_W-1:0]          req_color,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic signed [WORD_W-1:0]   rsp_pos_x,
   output logic signed [WORD_W-1:0]   rsp_pos_y,
   output logic                       rsp_tex_u,
   output logic                       rsp_tex_v,
   output logic [SLOT_O_W-1:0]        rsp_slot,
   output logic                       rsp_slot_is_new,
   output logic [WORD_W-1:0]          rsp_texture_out,
   output logic [WORD_W-1:0]          rsp_vertex_color,
   output logic [QUADS_W-1:0]         rsp_batch_quads,
   output logic [BSLOTS_W-1:0]        rsp_batch_slots,
   output logic                       rsp_last
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int SU_W   = $clog2(NUM_SLOTS + 1);
   localparam int SUM_W  = WORD_W + 2;
   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (WORD_W-1)) - 1);
   localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd1 <<< (WORD_W-1));

   // batch state
   logic [SU_W-1:0]    slots_used_ff, slots_used_in;
   logic [QUADS_W-1:0] quad_count_ff, quad_count_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;

   // latched request
   logic [WORD_W-1:0]        tex_ff, color_ff;
   logic signed [WORD_W-1:0] h0x_ff, h0y_ff, h1x_ff, h1y_ff, tx_ff, ty_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic                     is_new_ff;

   // slot table
   logic [WORD_W-1:0] slot_mem [NUM_SLOTS];
   logic [WORD_W-1:0] rd_ff;

   // result registers
   logic                     valid_ff;
   logic                     kind_ff;
   logic signed [WORD_W-1:0] pos_x_ff, pos_y_ff;
   logic                     u_ff, v_ff;
   logic [SLOT_O_W-1:0]      oslot_ff;
   logic                     onew_ff;
   logic [WORD_W-1:0]        otex_ff, ocolor_ff;
   logic [QUADS_W-1:0]       bq_ff;
   logic [BSLOTS_W-1:0]      bs_ff;
   logic                     last_ff;

   logic [LIMIT_W-1:0]       limit_eff;
   logic [WORD_W-1:0]        cmp_id;
   logic                     hit, at_end;
   logic                     s0, s1;
   logic signed [SUM_W-1:0]  sum_x, sum_y;
   logic signed [WORD_W-1:0] sat_x, sat_y;

   // effective quad limit, clamped to 1..MAX_QUADS
   always_comb begin
      if (quad_limit == '0) begin
         limit_eff = LIMIT_W'(1);
      end else if (quad_limit > LIMIT_W'(MAX_QUADS)) begin
         limit_eff = LIMIT_W'(MAX_QUADS);
      end else begin
         limit_eff = quad_limit;
      end
   end

   assign sts.flush_due = (quad_count_ff >= limit_eff) ||
                          (slots_used_ff > SU_W'(NUM_SLOTS - 1));

   // slot search compare, one entry per cycle
   assign cmp_id          = (idx_ff == '0) ? white_id : rd_ff;
   assign hit             = (cmp_id == tex_ff);
   assign at_end          = (SU_W'(idx_ff) == slots_used_ff - SU_W'(1));
   assign sts.search_done = hit | at_end;

   // batch bookkeeping
   always_comb begin
      slots_used_in = slots_used_ff;
      quad_count_in = quad_count_ff;
      idx_in        = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end
      if (cmd.emit_mark) begin
         slots_used_in = SU_W'(1);
         quad_count_in = '0;
      end
      if (cmd.search) begin
         if (sts.search_done) begin
            quad_count_in = quad_count_ff + QUADS_W'(1);
            if (!hit) begin
               slots_used_in = slots_used_ff + SU_W'(1);
            end
         end else begin
            idx_in = idx_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= SU_W'(1);
         quad_count_ff <= '0;
         idx_ff        <= '0;
      end else begin
         slots_used_ff <= slots_used_in;
         quad_count_ff <= quad_count_in;
         idx_ff        <= idx_in;
      end
   end

   // slot table write on a new binding, registered read of the next entry
   always_ff @(posedge clock) begin
      if (cmd.search && sts.search_done && !hit) begin
         slot_mem[SLOT_W'(slots_used_ff)] <= tex_ff;
      end
      rd_ff <= slot_mem[idx_in];
   end

   // request capture and slot result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tex_ff   <= req_texture_id;
         color_ff <= req_color;
         h0x_ff   <= req_axis0_x >>> 1;
         h0y_ff   <= req_axis0_y >>> 1;
         h1x_ff   <= req_axis1_x >>> 1;
         h1y_ff   <= req_axis1_y >>> 1;
         tx_ff    <= req_trans_x;
         ty_ff    <= req_trans_y;
      end
      if (cmd.search && sts.search_done) begin
         slot_ff   <= hit ? idx_ff : SLOT_W'(slots_used_ff);
         is_new_ff <= !hit;
      end
   end

   // corner position: translation plus or minus each half axis, saturated
   assign s0 = cmd.corner[0] ^ cmd.corner[1];
   assign s1 = cmd.corner[1];

   always_comb begin
      sum_x = SUM_W'(tx_ff)
            + (s0 ? SUM_W'(h0x_ff) : -SUM_W'(h0x_ff))
            + (s1 ? SUM_W'(h1x_ff) : -SUM_W'(h1x_ff));
      sum_y = SUM_W'(ty_ff)
            + (s0 ? SUM_W'(h0y_ff) : -SUM_W'(h0y_ff))
            + (s1 ? SUM_W'(h1y_ff) : -SUM_W'(h1y_ff));
      if (sum_x > POS_MAX) begin
         sat_x = POS_MAX[WORD_W-1:0];
      end else if (sum_x < POS_MIN) begin
         sat_x = POS_MIN[WORD_W-1:0];
      end else begin
         sat_x = sum_x[WORD_W-1:0];
      end
      if (sum_y > POS_MAX) begin
         sat_y = POS_MAX[WORD_W-1:0];
      end else if (sum_y < POS_MIN) begin
         sat_y = POS_MIN[WORD_W-1:0];
      end else begin
         sat_y = sum_y[WORD_W-1:0];
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_mark | cmd.emit_vtx;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.emit_mark) begin
         kind_ff   <= KIND_MARKER;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         u_ff      <= 1'b0;
         v_ff      <= 1'b0;
         oslot_ff  <= '0;
         onew_ff   <= 1'b0;
         otex_ff   <= '0;
         ocolor_ff <= '0;
         bq_ff     <= quad_count_ff;
         bs_ff     <= BSLOTS_W'(slots_used_ff);
         last_ff   <= cmd.mark_last;
      end else if (cmd.emit_vtx) begin
         kind_ff   <= KIND_VERTEX;
         pos_x_ff  <= sat_x;
         pos_y_ff  <= sat_y;
         u_ff      <= s0;
         v_ff      <= s1;
         oslot_ff  <= SLOT_O_W'(slot_ff);
         onew_ff   <= is_new_ff;
         otex_ff   <= tex_ff;
         ocolor_ff <= color_ff;
         bq_ff     <= '0;
         bs_ff     <= '0;
         last_ff   <= (cmd.corner == 2'd3);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_tex_u        = u_ff;
   assign rsp_tex_v        = v_ff;
   assign rsp_slot         = oslot_ff;
   assign rsp_slot_is_new  = onew_ff;
   assign rsp_texture_out  = otex_ff;
   assign rsp_vertex_color = ocolor_ff;
   assign rsp_batch_quads  = bq_ff;
   assign rsp_batch_slots  = bs_ff;
   assign rsp_last         = last_ff;

endmodule

@@ hdl/quad_batch_vertex_setup_unit.sv @@
// start is registered into the controller state; each result is then registered onto the ports
// draw: forced marker if due, then search one slot entry per cycle up to a hit or the last in use
// then four vertices; a new draw or close is taken only in idle, after the previous one is through
// close: one marker out; results come one per cycle on rsp_valid outside the slot search, no stall
// next start is taken while the last vertex of the previous request is on the result ports
// reset (synchronous): idle, slots in use 1, quad count 0, registers to defaults
module quad_batch_vertex_setup_unit
   import qbv_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [WORD_W-1:0]          req_texture_id,
   input  logic signed [WORD_W-1:0]   req_axis0_x,
   input  logic signed [WORD_W-1:0]   req_axis0_y,
   input  logic signed [WORD_W-1:0]   req_axis1_x,
   input  logic signed [WORD_W-1:0]   req_axis1_y,
   input  logic signed [WORD_W-1:0]   req_trans_x,
   input  logic signed [WORD_W-1:0]   req_trans_y,
   input  logic [WORD_W-1:0]          req_color,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic signed [WORD_W-1:0]   rsp_pos_x,
   output logic signed [WORD_W-1:0]   rsp_pos_y,
   output logic                       rsp_tex_u,
   output logic                       rsp_tex_v,
   output logic [SLOT_O_W-1:0]        rsp_slot,
   output logic                       rsp_slot_is_new,
   output logic [WORD_W-1:0]          rsp_texture_out,
   output logic [WORD_W-1:0]          rsp_vertex_color,
   output logic [QUADS_W-1:0]         rsp_batch_quads,
   output logic [BSLOTS_W-1:0]        rsp_batch_slots,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [WORD_W-1:0]          pwdata,
   output logic [WORD_W-1:0]          prdata,
   output logic                       pready
);

   logic [WORD_W-1:0]  white_id;
   logic [LIMIT_W-1:0] quad_limit;
   qbv_cmd_type        cmd;
   qbv_sts_type        sts;

   // configuration registers
   qbv_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .white_id   (white_id),
      .quad_limit (quad_limit)
   );

   // sequencing
   qbv_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .busy   (busy),
      .sts    (sts),
      .cmd    (cmd)
   );

   // slot search, corner math and result registers
   qbv_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .white_id         (white_id),
      .quad_limit       (quad_limit),
      .req_texture_id   (req_texture_id),
      .req_axis0_x      (req_axis0_x),
      .req_axis0_y      (req_axis0_y),
      .req_axis1_x      (req_axis1_x),
      .req_axis1_y      (req_axis1_y),
      .req_trans_x      (req_trans_x),
      .req_trans_y      (req_trans_y),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_slot         (rsp_slot),
      .rsp_slot_is_new  (rsp_slot_is_new),
      .rsp_texture_out  (rsp_texture_out),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_batch_quads  (rsp_batch_quads),
      .rsp_batch_slots  (rsp_batch_slots),
      .rsp_last         (rsp_last)
   );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
   import qbv_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_SLOTS    = NUM_SLOTS_DEFAULT;
   localparam int MAX_REPORTS  = 10;

   localparam logic [PADDR_W-1:0] ADDR_WHITE = {REG_WHITE, 2'b00};
   localparam logic [PADDR_W-1:0] ADDR_LIMIT = {REG_LIMIT, 2'b00};

   localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;

   // one request as the sender sees it
   typedef struct {
      logic                     opcode;
      logic [WORD_W-1:0]        texture_id;
      logic signed [WORD_W-1:0] axis0_x;
      logic signed [WORD_W-1:0] axis0_y;
      logic signed [WORD_W-1:0] axis1_x;
      logic signed [WORD_W-1:0] axis1_y;
      logic signed [WORD_W-1:0] trans_x;
      logic signed [WORD_W-1:0] trans_y;
      logic [WORD_W-1:0]        color;
   } quad_req_type;

   // one vertex or end-of-batch marker
   typedef struct {
      logic                     kind;
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic                     tex_u;
      logic                     tex_v;
      logic [SLOT_O_W-1:0]      slot;
      logic                     slot_is_new;
      logic [WORD_W-1:0]        texture_out;
      logic [WORD_W-1:0]        vertex_color;
      logic [QUADS_W-1:0]       batch_quads;
      logic [BSLOTS_W-1:0]      batch_slots;
      logic                     last;
   } vertex_rsp_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     start            = 1'b0;
   logic                     busy;
   logic                     req_opcode       = OP_DRAW;
   logic [WORD_W-1:0]        req_texture_id   = '0;
   logic signed [WORD_W-1:0] req_axis0_x      = '0;
   logic signed [WORD_W-1:0] req_axis0_y      = '0;
   logic signed [WORD_W-1:0] req_axis1_x      = '0;
   logic signed [WORD_W-1:0] req_axis1_y      = '0;
   logic signed [WORD_W-1:0] req_trans_x      = '0;
   logic signed [WORD_W-1:0] req_trans_y      = '0;
   logic [WORD_W-1:0]        req_color        = '0;
   logic                     rsp_valid;
   logic                     rsp_kind;
   logic signed [WORD_W-1:0] rsp_pos_x;
   logic signed [WORD_W-1:0] rsp_pos_y;
   logic                     rsp_tex_u;
   logic                     rsp_tex_v;
   logic [SLOT_O_W-1:0]      rsp_slot;
   logic                     rsp_slot_is_new;
   logic [WORD_W-1:0]        rsp_texture_out;
   logic [WORD_W-1:0]        rsp_vertex_color;
   logic [QUADS_W-1:0]       rsp_batch_quads;
   logic [BSLOTS_W-1:0]      rsp_batch_slots;
   logic                     rsp_last;
   logic                     psel             = 1'b0;
   logic                     penable          = 1'b0;
   logic                     pwrite           = 1'b0;
   logic [PADDR_W-1:0]       paddr            = '0;
   logic [WORD_W-1:0]        pwdata           = '0;
   logic [WORD_W-1:0]        prdata;
   logic                     pready;

   // shadow copy of the block state
   logic [WORD_W-1:0]  white_id_model = WHITE_RESET;
   logic [LIMIT_W-1:0] limit_model    = LIMIT_RESET;
   logic [WORD_W-1:0]  bound_textures[NUM_SLOTS];
   int                 slots_bound      = 1;
   int                 batch_quad_count = 0;

   vertex_rsp_type    vertices_due[$];
   logic [WORD_W-1:0] texture_pool[4];
   int                mismatch_count = 0;
   int                cycle_count    = 0;

   quad_batch_vertex_setup_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_texture_id   (req_texture_id),
      .req_axis0_x      (req_axis0_x),
      .req_axis0_y      (req_axis0_y),
      .req_axis1_x      (req_axis1_x),
      .req_axis1_y      (req_axis1_y),
      .req_trans_x      (req_trans_x),
      .req_trans_y      (req_trans_y),
      .req_color        (req_color),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_slot         (rsp_slot),
      .rsp_slot_is_new  (rsp_slot_is_new),
      .rsp_texture_out  (rsp_texture_out),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_batch_quads  (rsp_batch_quads),
      .rsp_batch_slots  (rsp_batch_slots),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic logic signed [WORD_W-1:0] clamp_word(longint v);
      if (v > POS_MAX) return W_MAX;
      if (v < POS_MIN) return W_MIN;
      return v[WORD_W-1:0];
   endfunction

   // end-of-batch marker, then the batch starts over
   function automatic void queue_batch_end(logic is_last);
      vertex_rsp_type r;
      r = '{default: '0};
      r.kind        = KIND_MARKER;
      r.batch_quads = QUADS_W'(batch_quad_count);
      r.batch_slots = BSLOTS_W'(slots_bound);
      r.last        = is_last;
      vertices_due = {vertices_due, r};
      batch_quad_count = 0;
      slots_bound      = 1;
   endfunction

   function automatic void predict_quad_setup(quad_req_type q);
      int          eff_limit;
      int          slot;
      logic        found;
      logic [WORD_W-1:0] held_id;
      longint      h0x, h0y, h1x, h1y, tx, ty, s0, s1;
      vertex_rsp_type r;
      if (q.opcode == OP_CLOSE) begin
         queue_batch_end(1'b1);
         return;
      end
      eff_limit = limit_model;
      if (eff_limit < 1) eff_limit = 1;
      if (eff_limit > MAX_QUADS) eff_limit = MAX_QUADS;
      // forced batch end on the quad limit or a full slot table
      if (batch_quad_count >= eff_limit || slots_bound > NUM_SLOTS - 1)
         queue_batch_end(1'b0);
      // lowest matching slot, else the next free one
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < slots_bound && i < NUM_SLOTS; i++) begin
         held_id = (i == 0) ? white_id_model : bound_textures[i];
         if (!found && held_id == q.texture_id) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         slot = slots_bound;
         if (slot < NUM_SLOTS) bound_textures[slot] = q.texture_id;
         slots_bound++;
      end
      // half axes are floor halves
      h0x = longint'(q.axis0_x) >>> 1;
      h0y = longint'(q.axis0_y) >>> 1;
      h1x = longint'(q.axis1_x) >>> 1;
      h1y = longint'(q.axis1_y) >>> 1;
      tx  = longint'(q.trans_x);
      ty  = longint'(q.trans_y);
      // corners in order (-,-) (+,-) (+,+) (-,+)
      for (int k = 0; k < 4; k++) begin
         s0 = (k == 1 || k == 2) ? 1 : -1;
         s1 = (k >= 2) ? 1 : -1;
         r = '{default: '0};
         r.kind         = KIND_VERTEX;
         r.pos_x        = clamp_word(tx + s0 * h0x + s1 * h1x);
         r.pos_y        = clamp_word(ty + s0 * h0y + s1 * h1y);
         r.tex_u        = (k == 1 || k == 2);
         r.tex_v        = (k >= 2);
         r.slot         = SLOT_O_W'(slot);
         r.slot_is_new  = !found;
         r.texture_out  = q.texture_id;
         r.vertex_color = q.color;
         r.last         = (k == 3);
         vertices_due = {vertices_due, r};
      end
      batch_quad_count++;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         if (mismatch_count < MAX_REPORTS)
            $display("mismatch on %s: expected %0h actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // compare every strobed result with the oldest expectation
   always @(posedge clock) begin : check_vertices
      vertex_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (vertices_due.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("result with nothing expected: kind %0h", rsp_kind);
            mismatch_count++;
         end else begin
            want = vertices_due.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("pos_x", want.pos_x, rsp_pos_x);
            check_field("pos_y", want.pos_y, rsp_pos_y);
            check_field("tex_u", want.tex_u, rsp_tex_u);
            check_field("tex_v", want.tex_v, rsp_tex_v);
            check_field("slot", want.slot, rsp_slot);
            check_field("slot_is_new", want.slot_is_new, rsp_slot_is_new);
            check_field("texture_out", want.texture_out, rsp_texture_out);
            check_field("vertex_color", want.vertex_color, rsp_vertex_color);
            check_field("batch_quads", want.batch_quads, rsp_batch_quads);
            check_field("batch_slots", want.batch_slots, rsp_batch_slots);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_quad(quad_req_type q);
      @(negedge clock);
      start          <= 1'b1;
      req_opcode     <= q.opcode;
      req_texture_id <= q.texture_id;
      req_axis0_x    <= q.axis0_x;
      req_axis0_y    <= q.axis0_y;
      req_axis1_x    <= q.axis1_x;
      req_axis1_y    <= q.axis1_y;
      req_trans_x    <= q.trans_x;
      req_trans_y    <= q.trans_y;
      req_color      <= q.color;
      do @(posedge clock); while (busy !== 1'b0);
      predict_quad_setup(q);
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic random_gap(int pct);
      if ($urandom_range(0, 99) < pct) pause_sender($urandom_range(1, 6));
   endtask

   // hold off until the block has delivered everything and gone quiet
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (vertices_due.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] random_coord();
      int v;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: begin
            v = $urandom_range(0, 2097151) - 1048576;
            return v;
         end
         2: begin
            case ($urandom_range(0, 4))
               0: return W_MAX;
               1: return W_MIN;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: begin
            v = $urandom;
            return v >>> $urandom_range(4, 12);
         end
      endcase
   endfunction

   function automatic quad_req_type make_quad(logic op, logic [WORD_W-1:0] tex);
      quad_req_type q;
      q.opcode     = op;
      q.texture_id = tex;
      q.axis0_x    = random_coord();
      q.axis0_y    = random_coord();
      q.axis1_x    = random_coord();
      q.axis1_y    = random_coord();
      q.trans_x    = random_coord();
      q.trans_y    = random_coord();
      q.color      = $urandom;
      return q;
   endfunction

   function automatic quad_req_type fixed_quad(logic [WORD_W-1:0] tex,
         logic signed [WORD_W-1:0] a0x, logic signed [WORD_W-1:0] a0y,
         logic signed [WORD_W-1:0] a1x, logic signed [WORD_W-1:0] a1y,
         logic signed [WORD_W-1:0] tx, logic signed [WORD_W-1:0] ty,
         logic [WORD_W-1:0] col);
      quad_req_type q;
      q.opcode     = OP_DRAW;
      q.texture_id = tex;
      q.axis0_x    = a0x;
      q.axis0_y    = a0y;
      q.axis1_x    = a1x;
      q.axis1_y    = a1y;
      q.trans_x    = tx;
      q.trans_y    = ty;
      q.color      = col;
      return q;
   endfunction

   function automatic logic [WORD_W-1:0] choose_texture();
      case ($urandom_range(0, 9))
         0, 1: return white_id_model;
         8: return $urandom;
         default: return texture_pool[$urandom_range(0, 3)];
      endcase
   endfunction

   task automatic refresh_pool();
      foreach (texture_pool[i]) texture_pool[i] = $urandom;
   endtask

   // ---------------------------------------------------------------- register port

   task automatic csr_write(logic [PADDR_W-1:0] addr, logic [WORD_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == ADDR_WHITE) white_id_model = data;
      else limit_model = data[LIMIT_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(logic [PADDR_W-1:0] addr);
      logic [WORD_W-1:0] want;
      want = (addr == ADDR_WHITE) ? white_id_model : WORD_W'(limit_model);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      check_field("prdata", want, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_register(logic [PADDR_W-1:0] addr, logic [WORD_W-1:0] data);
      csr_write(addr, data);
      csr_check(addr);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic run_random(int count, int close_pct, int gap_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < close_pct) send_quad(make_quad(OP_CLOSE, $urandom));
         else send_quad(make_quad(OP_DRAW, choose_texture()));
         random_gap(gap_pct);
      end
   endtask

   task automatic test_register_reset();
      csr_check(ADDR_WHITE);
      csr_check(ADDR_LIMIT);
   endtask

   task automatic test_directed();
      // empty batch close, then field extremes at reset settings
      send_quad(make_quad(OP_CLOSE, $urandom));
      send_quad(fixed_quad(32'h0, 0, 0, 0, 0, 0, 0, 32'h0));
      send_quad(fixed_quad(32'h1234_5678, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                           32'hFFFF_FFFF));
      send_quad(fixed_quad(32'h1234_5678, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                           32'h0000_0080));
      // odd values: floor halves
      send_quad(fixed_quad(32'hFFFF_FFFF, -1, -1, -1, -1, 0, 0, 32'h55AA_55AA));
      send_quad(fixed_quad(32'h0000_0001, 1, 3, -3, 5, -1, -1, 32'hAA55_AA55));
      send_quad(fixed_quad(32'h1234_5678, W_MAX, W_MIN, W_MIN, W_MAX, 0, 0, 32'h0102_0304));
      send_quad(fixed_quad(32'h0, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN, 32'hF0F0_F0F0));
      send_quad(make_quad(OP_CLOSE, $urandom));
      send_quad(make_quad(OP_CLOSE, $urandom));
      // white texture moved to all ones
      wait_drained();
      set_register(ADDR_WHITE, 32'hFFFF_FFFF);
      send_quad(make_quad(OP_DRAW, 32'hFFFF_FFFF));
      send_quad(make_quad(OP_DRAW, 32'h0));
      send_quad(make_quad(OP_DRAW, 32'h0));
      // smallest quad limit: a marker before every draw
      wait_drained();
      set_register(ADDR_LIMIT, 1);
      repeat (3) send_quad(make_quad(OP_DRAW, $urandom));
      // zero limit acts as one
      wait_drained();
      set_register(ADDR_LIMIT, 0);
      repeat (2) send_quad(make_quad(OP_DRAW, $urandom));
      wait_drained();
      set_register(ADDR_LIMIT, 2);
      repeat (3) send_quad(make_quad(OP_DRAW, 32'hFFFF_FFFF));
      send_quad(make_quad(OP_CLOSE, $urandom));
      wait_drained();
   endtask

   // mostly fresh textures so the slot table fills and forces batch ends
   task automatic test_slot_fill();
      logic [WORD_W-1:0] seen[$];
      logic [WORD_W-1:0] tex;
      set_register(ADDR_WHITE, $urandom);
      set_register(ADDR_LIMIT, MAX_QUADS);
      for (int n = 0; n < 80; n++) begin
         if ($urandom_range(0, 99) < 5) begin
            send_quad(make_quad(OP_CLOSE, $urandom));
         end else begin
            case ($urandom_range(0, 9))
               0: tex = white_id_model;
               1, 2: tex = (seen.size() != 0) ? seen[$urandom_range(0, seen.size() - 1)]
                                              : $urandom;
               default: tex = $urandom;
            endcase
            seen = {seen, tex};
            send_quad(make_quad(OP_DRAW, tex));
         end
         random_gap(30);
      end
      wait_drained();
   endtask

   task automatic test_quad_limits();
      int limits[5] = '{3, 1, 7, 0, 2};
      foreach (limits[i]) begin
         refresh_pool();
         set_register(ADDR_LIMIT, limits[i]);
         run_random(25, 10, 40);
         wait_drained();
      end
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 4; phase++) begin
         refresh_pool();
         set_register(ADDR_WHITE, ($urandom_range(0, 1) != 0) ? texture_pool[0] : $urandom);
         set_register(ADDR_LIMIT, $urandom_range(1, 40));
         run_random(40, 8, 25);
         wait_drained();
      end
   endtask

   // limit above the maximum clamps; long run with no idling
   task automatic test_limit_clamp();
      refresh_pool();
      set_register(ADDR_WHITE, $urandom);
      set_register(ADDR_LIMIT, 2047);
      send_quad(make_quad(OP_CLOSE, $urandom));
      run_random(120, 0, 0);
   endtask

   // ---------------------------------------------------------------- sequencing

   initial begin : run_tests
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_directed();
      test_slot_fill();
      test_quad_limits();
      test_random_mix();
      test_limit_clamp();
      wait_drained();
      if (mismatch_count == 0 && vertices_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hdl/qbv_pkg.sv
hdl/qbv_csr.sv
hdl/qbv_ctrl.sv
hdl/qbv_datapath.sv
hdl/quad_batch_vertex_setup_unit.sv
tb/sv/tb_top.sv
